[design/pal_pkg.sv]
// Package for the positional array list engine.
// Holds sizes, status and operation codes, sequencer states and the word types.
// Depends on nothing.
`default_nettype none

package pal_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int FILL_W   = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_SEARCH   = 2'd2,
		OP_TRAVERSE = 2'd3
	} op_t;

	localparam logic [2:0] STS_DONE     = 3'd0;
	localparam logic [2:0] STS_BADPOS   = 3'd1;
	localparam logic [2:0] STS_FULL     = 3'd2;
	localparam logic [2:0] STS_FOUND    = 3'd3;
	localparam logic [2:0] STS_NOTFOUND = 3'd4;
	localparam logic [2:0] STS_ELEMENT  = 3'd5;
	localparam logic [2:0] STS_EMPTY    = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SHIFT,
		ST_INS_PUT,
		ST_DEL_SHIFT,
		ST_SEARCH,
		ST_TRV_RD,
		ST_TRV_OUT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
		logic [6:0]         position;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         index;
		logic signed [31:0] element;
		logic [6:0]         length;
		logic               last;
	} out_word_t;

endpackage

`default_nettype wire

[design/positional_array_list_engine_core.sv]
// Positional array list engine: ordered list of signed 32-bit words.
// Depends on pal_pkg and pal_ram.
//
// Usage: in_data carries mode, value and position, taken when in_valid and
// in_ready are both high. Results leave on out_data under out_valid/out_ready;
// the final result of each input word has last set. One input word is worked
// on at a time; in_ready is high only while the sequencer is idle, and a word
// is taken even while the previous final result still sits in the output
// register.
// The pace from one accepted word to the next is set by the single read port
// of the entry RAM that one pointer walks: insert walks from the end of the
// list down to the position, delete from the position up to the end, search
// from the start up to the first match, and traverse emits each stored entry
// once the output register is free. Errors and empty-list cases skip the walk.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset empties the list (length zero) and drops any pending output; the RAM
// itself is not cleared since only entries below the length are ever read.
`default_nettype none

module positional_array_list_engine_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pal_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pal_pkg::out_word_t      out_data
);

	import pal_pkg::*;

	state_t             state_q, state_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [6:0]         ptr_q, ptr_d;
	logic               pend_q, pend_d;
	logic [ADDR_W-1:0]  paddr_q, paddr_d;
	logic               rd_done_q, rd_done_d;
	logic signed [31:0] value_q, value_d;
	logic [6:0]         pos_q, pos_d;
	logic [2:0]         res_status_q, res_status_d;
	logic [5:0]         res_index_q, res_index_d;
	out_word_t          out_q, out_d;
	logic               out_valid_q, out_valid_d;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [31:0]        ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [31:0]        ram_rdata;

	logic               in_fire;
	logic               slot_free;
	logic               ins_bad, ins_full, del_bad, list_empty, match;
	logic [6:0]         fill_ext;
	logic [6:0]         last_idx;
	logic               out_load;

	pal_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign fill_ext   = 7'(fill_q);
	assign last_idx   = fill_ext - 7'd1;
	assign ins_bad    = in_data.position > fill_ext;
	assign ins_full   = fill_q >= FILL_W'(CAPACITY);
	assign del_bad    = in_data.position >= fill_ext;
	assign list_empty = (fill_q == '0);
	assign match      = pend_q && (ram_rdata == value_q);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (op_t'(in_data.mode))
						OP_INSERT: begin
							if (ins_bad || ins_full) begin
								state_d = ST_EMIT;
							end else if (in_data.position == fill_ext) begin
								state_d = ST_INS_PUT;
							end else begin
								state_d = ST_INS_SHIFT;
							end
						end
						OP_DELETE: begin
							if (del_bad || (in_data.position + 7'd1 == fill_ext)) begin
								state_d = ST_EMIT;
							end else begin
								state_d = ST_DEL_SHIFT;
							end
						end
						OP_SEARCH:   state_d = list_empty ? ST_EMIT : ST_SEARCH;
						OP_TRAVERSE: state_d = list_empty ? ST_EMIT : ST_TRV_RD;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_SHIFT: if (rd_done_q && pend_q) state_d = ST_INS_PUT;
			ST_INS_PUT:   state_d = ST_EMIT;
			ST_DEL_SHIFT: if (rd_done_q && pend_q) state_d = ST_EMIT;
			ST_SEARCH:    if (match || (rd_done_q && pend_q)) state_d = ST_EMIT;
			ST_TRV_RD:    state_d = ST_TRV_OUT;
			ST_TRV_OUT: begin
				if (slot_free) begin
					state_d = (ptr_q == last_idx) ? ST_IDLE : ST_TRV_RD;
				end
			end
			ST_EMIT:      if (slot_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// datapath and RAM control
	always_comb begin
		fill_d       = fill_q;
		ptr_d        = ptr_q;
		pend_d       = pend_q;
		paddr_d      = paddr_q;
		rd_done_d    = rd_done_q;
		value_d      = value_q;
		pos_d        = pos_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		out_d        = out_q;
		out_load     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = paddr_q;
		ram_wdata    = ram_rdata;
		ram_raddr    = ptr_q[ADDR_W-1:0];

		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					value_d     = in_data.value;
					pos_d       = in_data.position;
					pend_d      = 1'b0;
					rd_done_d   = 1'b0;
					res_index_d = '0;
					case (op_t'(in_data.mode))
						OP_INSERT: begin
							ptr_d = last_idx;
							if (ins_bad) begin
								res_status_d = STS_BADPOS;
							end else if (ins_full) begin
								res_status_d = STS_FULL;
							end else begin
								res_status_d = STS_DONE;
							end
						end
						OP_DELETE: begin
							ptr_d = in_data.position + 7'd1;
							if (del_bad) begin
								res_status_d = STS_BADPOS;
							end else begin
								res_status_d = STS_DONE;
								fill_d       = fill_q - FILL_W'(1);
							end
						end
						OP_SEARCH: begin
							ptr_d        = '0;
							res_status_d = STS_NOTFOUND;
						end
						OP_TRAVERSE: begin
							ptr_d        = '0;
							res_status_d = STS_EMPTY;
						end
						default: ;
					endcase
				end
			end
			ST_INS_SHIFT: begin
				// write back the word read last cycle one slot higher
				ram_we = pend_q;
				if (!rd_done_q) begin
					pend_d  = 1'b1;
					paddr_d = ADDR_W'(ptr_q + 7'd1);
					if (ptr_q == pos_q) begin
						rd_done_d = 1'b1;
					end else begin
						ptr_d = ptr_q - 7'd1;
					end
				end else begin
					pend_d = 1'b0;
				end
			end
			ST_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[ADDR_W-1:0];
				ram_wdata = value_q;
				fill_d    = fill_q + FILL_W'(1);
			end
			ST_DEL_SHIFT: begin
				// write back one slot lower; fill already holds the new length
				ram_we = pend_q;
				if (!rd_done_q) begin
					pend_d  = 1'b1;
					paddr_d = ADDR_W'(ptr_q - 7'd1);
					if (ptr_q == fill_ext) begin
						rd_done_d = 1'b1;
					end else begin
						ptr_d = ptr_q + 7'd1;
					end
				end else begin
					pend_d = 1'b0;
				end
			end
			ST_SEARCH: begin
				if (match) begin
					res_status_d = STS_FOUND;
					res_index_d  = 6'(paddr_q);
				end
				if (!rd_done_q) begin
					pend_d  = 1'b1;
					paddr_d = ptr_q[ADDR_W-1:0];
					if (ptr_q == last_idx) begin
						rd_done_d = 1'b1;
					end else begin
						ptr_d = ptr_q + 7'd1;
					end
				end else begin
					pend_d = 1'b0;
				end
			end
			ST_TRV_RD: ;
			ST_TRV_OUT: begin
				if (slot_free) begin
					out_load      = 1'b1;
					out_d.status  = STS_ELEMENT;
					out_d.index   = 6'(ptr_q);
					out_d.element = ram_rdata;
					out_d.length  = fill_ext;
					out_d.last    = (ptr_q == last_idx);
					ptr_d         = ptr_q + 7'd1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_load      = 1'b1;
					out_d.status  = res_status_q;
					out_d.index   = res_index_q;
					out_d.element = '0;
					out_d.length  = fill_ext;
					out_d.last    = 1'b1;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			rd_done_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			out_valid_q <= out_valid_d;
			pend_q      <= pend_d;
			rd_done_q   <= rd_done_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		paddr_q      <= paddr_d;
		value_q      <= value_d;
		pos_q        <= pos_d;
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
		out_q        <= out_d;
	end

endmodule

`default_nettype wire

[design/pal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for positional_array_list_engine_core.
// Keeps its own copy of the list and checks every result word in order.
// Depends on pal_pkg and the engine RTL.

module testbench;
	import pal_pkg::*;

	localparam int RANDOM_WORDS = 500;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 200;
	localparam int SCRIPT_LEN   = 25;

	typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_style_t;

	// One row of the opening script. When fixed is set, the result is a single
	// word with the given status and length, written in by hand.
	typedef struct packed {
		op_t                mode;
		logic signed [31:0] value;
		logic [6:0]         position;
		bit                 fixed;
		logic [2:0]         status;
		logic [6:0]         length;
	} script_row_t;

	localparam script_row_t OPENING_SCRIPT [SCRIPT_LEN] = '{
		'{OP_TRAVERSE, 32'sd0,           7'd0,   1'b1, STS_EMPTY,    7'd0},
		'{OP_SEARCH,   32'sd0,           7'd0,   1'b1, STS_NOTFOUND, 7'd0},
		'{OP_DELETE,   32'sd0,           7'd0,   1'b1, STS_BADPOS,   7'd0},
		'{OP_INSERT,   32'sd5,           7'd1,   1'b1, STS_BADPOS,   7'd0},
		'{OP_INSERT,   -32'sd1,          7'd127, 1'b1, STS_BADPOS,   7'd0},
		'{OP_INSERT,   32'sh7FFFFFFF,    7'd0,   1'b1, STS_DONE,     7'd1},
		'{OP_INSERT,   32'sh80000000,    7'd0,   1'b1, STS_DONE,     7'd2},
		'{OP_INSERT,   -32'sd1,          7'd2,   1'b1, STS_DONE,     7'd3},
		'{OP_INSERT,   32'sd0,           7'd1,   1'b1, STS_DONE,     7'd4},
		'{OP_INSERT,   32'sd0,           7'd4,   1'b1, STS_DONE,     7'd5},
		'{OP_TRAVERSE, 32'sd0,           7'd0,   1'b0, STS_DONE,     7'd0},
		'{OP_SEARCH,   32'sd0,           7'd0,   1'b0, STS_DONE,     7'd0},
		'{OP_SEARCH,   32'sh80000000,    7'd0,   1'b0, STS_DONE,     7'd0},
		'{OP_SEARCH,   32'sd12345,       7'd0,   1'b1, STS_NOTFOUND, 7'd5},
		'{OP_DELETE,   32'sd0,           7'd5,   1'b1, STS_BADPOS,   7'd5},
		'{OP_DELETE,   32'sd0,           7'd127, 1'b1, STS_BADPOS,   7'd5},
		'{OP_INSERT,   32'sd7,           7'd6,   1'b1, STS_BADPOS,   7'd5},
		'{OP_DELETE,   32'sd0,           7'd4,   1'b1, STS_DONE,     7'd4},
		'{OP_DELETE,   32'sd0,           7'd0,   1'b1, STS_DONE,     7'd3},
		'{OP_DELETE,   32'sd0,           7'd1,   1'b1, STS_DONE,     7'd2},
		'{OP_TRAVERSE, 32'sd0,           7'd0,   1'b0, STS_DONE,     7'd0},
		'{OP_SEARCH,   32'sh7FFFFFFF,    7'd0,   1'b1, STS_NOTFOUND, 7'd2},
		'{OP_DELETE,   32'sd0,           7'd0,   1'b1, STS_DONE,     7'd1},
		'{OP_DELETE,   32'sd0,           7'd0,   1'b1, STS_DONE,     7'd0},
		'{OP_TRAVERSE, 32'sd0,           7'd0,   1'b1, STS_EMPTY,    7'd0}
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// Shadow copy of the list
	logic signed [31:0] list_mem [CAPACITY];
	int                 list_len = 0;

	out_word_t step_words [$];
	out_word_t awaited_words [$];

	int words_sent    = 0;
	int results_seen  = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;
	int burst_left    = 0;
	int traversals    = 0;
	int full_rejects  = 0;
	int peak_len      = 0;

	rx_style_t rx_style = RX_OPEN;
	int        rx_left  = 0;

	positional_array_list_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	// Work out the result words of one list operation and update the shadow list.
	function automatic void apply_list_op(input in_word_t w);
		int        i;
		int        pos;
		bit        hit;
		out_word_t r;
		step_words.delete();
		pos    = int'(w.position);
		r      = '0;
		r.last = 1'b1;
		case (op_t'(w.mode))
			OP_INSERT: begin
				if (pos > list_len) begin
					r.status = STS_BADPOS;
				end else if (list_len >= CAPACITY) begin
					r.status = STS_FULL;
					full_rejects++;
				end else begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pos] = w.value;
					list_len++;
					r.status = STS_DONE;
				end
				r.length = 7'(list_len);
				step_words.push_back(r);
			end
			OP_DELETE: begin
				if (pos >= list_len) begin
					r.status = STS_BADPOS;
				end else begin
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
					r.status = STS_DONE;
				end
				r.length = 7'(list_len);
				step_words.push_back(r);
			end
			OP_SEARCH: begin
				hit      = 1'b0;
				r.status = STS_NOTFOUND;
				for (i = 0; i < list_len && !hit; i++) begin
					if (list_mem[i] == w.value) begin
						hit      = 1'b1;
						r.status = STS_FOUND;
						r.index  = 6'(i);
					end
				end
				r.length = 7'(list_len);
				step_words.push_back(r);
			end
			OP_TRAVERSE: begin
				traversals++;
				r.length = 7'(list_len);
				if (list_len == 0) begin
					r.status = STS_EMPTY;
					step_words.push_back(r);
				end else begin
					for (i = 0; i < list_len; i++) begin
						r.status  = STS_ELEMENT;
						r.index   = 6'(i);
						r.element = list_mem[i];
						r.last    = (i == list_len - 1);
						step_words.push_back(r);
					end
				end
			end
			default: ;
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
	endfunction

	// Present one input word, hold it until taken, then idle per the burst plan.
	task automatic send_word(input in_word_t w, input bit fixed, input out_word_t fixed_word);
		int gap;
		in_data  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		apply_list_op(w);
		if (fixed)
			awaited_words.push_back(fixed_word);
		else
			foreach (step_words[k]) awaited_words.push_back(step_words[k]);
		words_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic note_mismatch(input string what, input out_word_t exp, input out_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"[%0t] %s: expected st=%0d idx=%0d el=%0d len=%0d last=%0d,",
				" got st=%0d idx=%0d el=%0d len=%0d last=%0d"},
				$realtime, what, exp.status, exp.index, exp.element, exp.length, exp.last,
				got.status, got.index, got.element, got.length, got.last);
	endtask

	// Receiver: switch at random between an open, a random and a periodic stall style.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 2));
			rx_left  = $urandom_range(20, 120);
		end
		rx_left--;
		case (rx_style)
			RX_OPEN:     out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= ($urandom_range(0, 9) < 6);
			RX_PERIODIC: out_ready <= ((rx_left % 7) < 3);
			default:     out_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		out_word_t exp;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_words.size() == 0) begin
					note_mismatch("unexpected word", '0, out_data);
				end else begin
					exp = awaited_words.pop_front();
					if (out_data.status !== exp.status || out_data.index !== exp.index ||
					    out_data.element !== exp.element || out_data.length !== exp.length ||
					    out_data.last !== exp.last)
						note_mismatch("mismatch", exp, out_data);
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("watchdog: no handshake for %0d cycles, %0d words still awaited",
			QUIET_LIMIT, awaited_words.size());
		$display("testbench failed");
		$finish;
	end

	initial begin
		in_word_t    w;
		out_word_t   fixed_word;
		script_row_t row;
		bit          growing;
		int          lingered;
		int          roll;
		growing  = 1'b1;
		lingered = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (OPENING_SCRIPT[n]) begin
			row               = OPENING_SCRIPT[n];
			w.mode            = row.mode;
			w.value           = row.value;
			w.position        = row.position;
			fixed_word        = '0;
			fixed_word.status = row.status;
			fixed_word.length = row.length;
			fixed_word.last   = 1'b1;
			send_word(w, row.fixed, fixed_word);
		end

		// Random part: alternate between filling the list and draining it.
		repeat (RANDOM_WORDS) begin
			if (growing && list_len == CAPACITY) begin
				lingered++;
				if (lingered > 12) begin
					growing  = 1'b0;
					lingered = 0;
				end
			end else if (!growing && list_len == 0) begin
				lingered++;
				if (lingered > 6) begin
					growing  = 1'b1;
					lingered = 0;
				end
			end

			roll = $urandom_range(0, 99);
			if (roll < 65)
				w.mode = growing ? OP_INSERT : OP_DELETE;
			else if (roll < 75)
				w.mode = growing ? OP_DELETE : OP_INSERT;
			else if (roll < 90)
				w.mode = OP_SEARCH;
			else
				w.mode = OP_TRAVERSE;

			roll = $urandom_range(0, 7);
			if (roll < 2)
				w.value = $urandom_range(0, 6) - 3;
			else if (roll == 2)
				w.value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			else
				w.value = $urandom;
			if (op_t'(w.mode) == OP_SEARCH && list_len > 0 && $urandom_range(0, 1))
				w.value = list_mem[$urandom_range(0, list_len - 1)];

			// Mostly in-range positions; a few land anywhere in the field.
			if ($urandom_range(0, 19) == 0)
				w.position = 7'($urandom_range(0, 127));
			else if (op_t'(w.mode) == OP_INSERT)
				w.position = 7'($urandom_range(0, list_len));
			else if (op_t'(w.mode) == OP_DELETE && list_len > 0)
				w.position = 7'($urandom_range(0, list_len - 1));
			else
				w.position = 7'($urandom_range(0, 127));

			send_word(w, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (awaited_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words (%0d traversals), checked %0d results, mismatches %0d",
			words_sent, traversals, results_seen, mismatches);
		$display("deepest list %0d entries, %0d inserts turned away as full",
			peak_len, full_rejects);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[sim.f]
design/pal_pkg.sv
design/pal_ram.sv
design/positional_array_list_engine_core.sv
tb/sv/testbench.sv
